### rtl/igs_pkg.sv
// igs_pkg: shared types and constants of the interpolated gain schedule unit
// used by igs_divider, igs_seq and interpolated_gain_schedule_unit
package igs_pkg;
  localparam int MaxPoints    = 8;
  localparam int IdxW         = $clog2(MaxPoints);
  localparam int FracBits     = 16;
  localparam int TW           = FracBits + 1;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_SMOOTH = 2'd1,
    MODE_HOLD   = 2'd2,
    MODE_ALT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_MODE  = 2'd1,
    CFG_BAND  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HYST, ST_ENDS, ST_SCAN, ST_FRAC, ST_DIV, ST_SM1, ST_SM2, ST_SM3,
    ST_MUL, ST_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

### rtl/igs_divider.sv
// igs_divider: restoring divider, one quotient bit per cycle, for the fraction
// depends on igs_pkg
module igs_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  igs_pkg::div_ctl_t    ctl,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output igs_pkg::div_sts_t    sts,
  output logic [igs_pkg::FracBits-1:0] quo
);
  import igs_pkg::*;

  localparam int CntW = $clog2(FracBits + 1);

  logic [32:0]         rem_r, rem_nxt;
  logic [31:0]         den_r, den_nxt;
  logic [FracBits-1:0] quo_r, quo_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [33:0]         trial;

  // operand load on start, else one shift and subtract step
  always_comb begin
    trial    = {rem_r, 1'b0} - {2'b00, den_r};
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      cnt_nxt  = CntW'(FracBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[FracBits-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], 1'b0};
        quo_nxt = {quo_r[FracBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy at zero count");
`endif
endmodule

### rtl/igs_seq.sv
// igs_seq: sequencer with table storage, shared multiplier and blend accumulator
// depends on igs_pkg and igs_divider
module igs_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [163:0]          item,
  input  logic [3:0]            point_count,
  input  igs_pkg::mode_t        mode,
  input  logic [30:0]           band,
  output logic                  busy,
  output logic                  done,
  output logic [96:0]           result
);
  import igs_pkg::*;

  state_t      st_r, st_nxt;
  logic [31:0] pos_m [MaxPoints];
  logic [31:0] gp_m  [MaxPoints];
  logic [31:0] gi_m  [MaxPoints];
  logic [31:0] gd_m  [MaxPoints];

  logic [163:0]  item_r;
  logic [31:0]   x_r, prev_r;
  logic          hist_r;
  logic [IdxW-1:0] k_r, seg_r;
  logic [IdxW-1:0] last_idx;
  logic [TW-1:0] t_r;
  logic [33:0]   t2_r;
  logic [1:0]    g_r;
  logic [31:0]   gp_r, gi_r, gd_r;
  logic          status_r;
  logic [31:0]   lo_r, hi_r;

  logic          kind;
  logic [2:0]    load_idx;
  logic [3:0]    cnt_eff;
  div_ctl_t      dctl;
  div_sts_t      dsts;
  logic [FracBits-1:0] dquo;
  logic [32:0]   num_w, den_w;
  logic [32:0]   diff;
  logic [31:0]   adiff;
  logic [31:0]   rd_pos_k, rd_pos_k1;
  logic          at_first, at_last, in_seg, scan_end;
  logic [31:0]   ga, gb;
  logic [65:0]   mul_a, mul_b;
  logic [48:0]   blend_w;

  assign kind     = item_r[0];
  assign load_idx = item_r[3:1];

  always_comb begin
    cnt_eff = point_count;
    if (point_count < 4'd2) cnt_eff = 4'd2;
    if (point_count > 4'(MaxPoints)) cnt_eff = 4'(MaxPoints);
  end
  assign last_idx = IdxW'(cnt_eff - 4'd1);

  assign rd_pos_k  = pos_m[k_r];
  assign rd_pos_k1 = pos_m[k_r + 1'b1];
  assign diff  = {item_r[163], item_r[163:132]} - {prev_r[31], prev_r};
  assign adiff = diff[32] ? 32'(-diff) : diff[31:0];
  assign num_w = {x_r[31], x_r} - {lo_r[31], lo_r};
  assign den_w = {hi_r[31], hi_r} - {lo_r[31], lo_r};

  // segment scan compares
  assign at_first = $signed(x_r) <= $signed(pos_m[0]);
  assign at_last  = $signed(x_r) >= $signed(pos_m[last_idx]);
  assign in_seg   = $signed(x_r) >= $signed(rd_pos_k) && $signed(x_r) < $signed(rd_pos_k1);
  assign scan_end = (k_r + 1'b1) >= last_idx;

  always_comb begin
    case (g_r)
      2'd0: begin ga = gp_m[seg_r]; gb = gp_m[seg_r + 1'b1]; end
      2'd1: begin ga = gi_m[seg_r]; gb = gi_m[seg_r + 1'b1]; end
      default: begin ga = gd_m[seg_r]; gb = gd_m[seg_r + 1'b1]; end
    endcase
  end
  // shared multiplier pair used for the blend
  assign mul_a   = 66'(ga) * 66'((TW+1)'(1 << FracBits) - {1'b0, t_r});
  assign mul_b   = 66'(gb) * 66'(t_r);
  assign blend_w = 49'((mul_a + mul_b) >> FracBits);

  assign dctl.start = (st_r == ST_FRAC) && !den_w[32] && den_w != '0 &&
                      !num_w[32] && num_w != '0 && num_w < den_w;

  igs_divider u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(num_w[31:0]), .den(den_w[31:0]),
    .sts(dsts), .quo(dquo)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (start) st_nxt = ST_HYST;
      ST_HYST: st_nxt = kind ? ST_ENDS : ST_OUT;
      ST_ENDS: st_nxt = ST_SCAN;
      // both table ends skip the fraction and its shaping
      ST_SCAN: begin
        if (at_first || at_last) st_nxt = ST_MUL;
        else if (in_seg || scan_end) st_nxt = ST_FRAC;
      end
      ST_FRAC: st_nxt = dctl.start ? ST_DIV : ST_SM1;
      ST_DIV:  if (dsts.done) st_nxt = ST_SM1;
      ST_SM1:  st_nxt = ST_SM2;
      ST_SM2:  st_nxt = ST_SM3;
      ST_SM3:  st_nxt = ST_MUL;
      ST_MUL:  if (g_r == 2'd2) st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      prev_r <= '0;
      hist_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (start) begin
          item_r   <= item;
          status_r <= 1'b0;
          gp_r <= '0; gi_r <= '0; gd_r <= '0;
          g_r <= 2'd0;
          k_r <= '0;
        end
        ST_HYST: begin
          if (!kind) begin
            if ({1'b0, load_idx} >= cnt_eff) status_r <= 1'b1;
            else begin
              pos_m[load_idx[IdxW-1:0]] <= item_r[35:4];
              gp_m[load_idx[IdxW-1:0]]  <= item_r[67:36];
              gi_m[load_idx[IdxW-1:0]]  <= item_r[99:68];
              gd_m[load_idx[IdxW-1:0]]  <= item_r[131:100];
              hist_r <= 1'b0;
            end
          end else begin
            if (hist_r && band != '0 && adiff < {1'b0, band}) x_r <= prev_r;
            else x_r <= item_r[163:132];
            hist_r <= 1'b1;
          end
        end
        ST_ENDS: begin
          prev_r <= x_r;
          seg_r  <= '0;
          t_r    <= '0;
        end
        ST_SCAN: begin
          // the end checks first, then one segment per cycle
          if (at_first) begin
            seg_r <= '0; t_r <= '0;
          end else if (at_last) begin
            seg_r <= last_idx - 1'b1; t_r <= TW'(1 << FracBits);
          end else if (in_seg) begin
            seg_r <= k_r; lo_r <= rd_pos_k; hi_r <= rd_pos_k1;
          end else if (scan_end) begin
            seg_r <= '0; lo_r <= pos_m[0]; hi_r <= pos_m[1];
          end else k_r <= k_r + 1'b1;
        end
        ST_FRAC: begin
          if (den_w[32] || den_w == '0 || num_w[32] || num_w == '0) t_r <= '0;
          else if (num_w >= den_w) t_r <= TW'(1 << FracBits);
        end
        ST_DIV: if (dsts.done) t_r <= {1'b0, dquo};
        ST_SM1: t2_r <= 34'((t_r * t_r) >> FracBits);
        ST_SM2: if (mode == MODE_SMOOTH)
          t_r <= TW'((t2_r * (34'(3 << FracBits) - 34'({t_r, 1'b0}))) >> FracBits);
        ST_SM3: if (mode == MODE_HOLD) t_r <= '0;
        ST_MUL: begin
          case (g_r)
            2'd0: gp_r <= blend_w[31:0];
            2'd1: gi_r <= blend_w[31:0];
            default: gd_r <= blend_w[31:0];
          endcase
          g_r <= g_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign busy   = st_r != ST_IDLE;
  assign done   = st_r == ST_OUT;
  assign result = {status_r, gd_r, gi_r, gp_r};

`ifndef NO_ASSERTIONS
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> st_r == ST_IDLE) else $error("done not followed by idle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == ST_IDLE) else $error("start while busy");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dsts.busy |-> st_r == ST_DIV) else $error("divider busy outside divide");
`endif
endmodule

### rtl/interpolated_gain_schedule_unit.sv
// interpolated_gain_schedule_unit: top level, stream ports and config registers
// depends on igs_pkg, igs_seq, igs_divider
// One item at a time. In the sequencer a load writes the table or flags its
// index as out of range, an evaluate at or beyond either end of the table skips
// the fraction, and an evaluate inside the table scans the segments and runs the
// bit-serial fraction divider when the fraction lies strictly between 0 and 1.
// The result waits in an output register; the next item is taken no sooner than
// the cycle after the result leaves it.
module interpolated_gain_schedule_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,  // point_index, point_position, point_kp,
                                  // point_ki, point_kd, sched_position, zero fill
  input  logic         in_tuser,  // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata, // gain_p, gain_i, gain_d, status, zero fill
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);
  import igs_pkg::*;

  logic [3:0]  count_r;
  mode_t       mode_r;
  logic [30:0] band_r;
  logic        busy, done, ovalid_r, start;
  logic [96:0] result, odata_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd2;
      mode_r  <= MODE_LINEAR;
      band_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COUNT: count_r <= cfg_wdata[3:0];
        CFG_MODE:  mode_r  <= mode_t'(cfg_wdata[1:0]);
        CFG_BAND:  band_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !busy && !ovalid_r;
  assign start     = in_tvalid && in_tready;

  igs_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start),
    .item({in_tdata[162:0], in_tuser}),
    .point_count(count_r), .mode(mode_r), .band(band_r),
    .busy(busy), .done(done), .result(result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (done) odata_r <= result;
    if (!rst_n) ovalid_r <= 1'b0;
    else if (done) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, odata_r};

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !ovalid_r) else $error("result overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(out_tdata))
    else $error("result dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready with pending result");
`endif
endmodule
